// ===== hdl/bre_pkg.sv =====
// Shared types and constants of the beat repeat effect unit.
package bre_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LOOP_LENGTH        = 3'd0,
        CFG_SIXTEENTH_SIZE     = 3'd1,
        CFG_RECORD_LENGTH      = 3'd2,
        CFG_SELECTED_SIXTEENTH = 3'd3,
        CFG_REPEAT_COUNT       = 3'd4,
        CFG_ENABLE             = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [23:0] loop_length;
        logic [16:0] sixteenth_size;
        logic [16:0] record_length;
        logic [3:0]  selected_sixteenth;
        logic [4:0]  repeat_count;
        logic        enable;
    } t_cfg;

    localparam logic [23:0] RST_LOOP_LENGTH        = 24'd96000;
    localparam logic [16:0] RST_SIXTEENTH_SIZE     = 17'd6000;
    localparam logic [16:0] RST_RECORD_LENGTH      = 17'd6000;
    localparam logic [3:0]  RST_SELECTED_SIXTEENTH = 4'd0;
    localparam logic [4:0]  RST_REPEAT_COUNT       = 5'd1;
    localparam logic        RST_ENABLE             = 1'b0;

    // Classification that the front end attaches to each queued sample.
    typedef struct packed {
        logic do_write;
        logic active;
    } t_class;

    typedef struct packed {
        logic recording;
        logic has_recording;
    } t_front_status;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Remainder unit: two dividend bits per cycle.
    localparam logic [4:0] MOD_PAIRS_FULL = 5'd16;
    localparam logic [4:0] MOD_PAIRS_IDX  = 5'd12;
    localparam int         IDX_ALIGN_BITS = 8;

endpackage

// ===== hdl/bre_mod_unit.sv =====
// Iterative restoring remainder unit, two quotient bits per cycle.
module bre_mod_unit
    import bre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [23:0] i_divisor,
    input  logic [4:0]  i_pairs,
    output logic        o_done,
    output logic [23:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [31:0] r_div;
    logic [23:0] r_dvs;
    logic [23:0] r_rem;
    logic [4:0]  r_left;
    logic [23:0] s1;
    logic [23:0] s2;

    function automatic logic [23:0] rem_step(input logic [23:0] rem, input logic b,
                                             input logic [23:0] d);
        logic [24:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[23:0];
    endfunction

    always_comb begin
        s1 = rem_step(r_rem, r_div[31], r_dvs);
        s2 = rem_step(s1, r_div[30], r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_div  <= i_dividend;
                r_dvs  <= i_divisor;
                r_left <= i_pairs;
            end else if (r_busy) begin
                r_rem  <= s2;
                r_div  <= {r_div[29:0], 2'b00};
                r_left <= r_left - 5'd1;
                if (r_left == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/bre_front.sv =====
// Front end: accepts samples, runs the recording control and queues classified beats.
module bre_front
    import bre_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 16,
    parameter int CW          = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [3:0]             i_phase,
    input  logic [31:0]            i_count,
    input  t_cfg                   i_cfg,
    input  logic [CW-1:0]          i_eff_rl,
    output logic                   o_q_valid,
    input  logic                   i_q_take,
    output logic [SAMPLE_BITS-1:0] o_q_sample,
    output logic [31:0]            o_q_count,
    output logic [AW-1:0]          o_q_waddr,
    output t_class                 o_q_class,
    output t_front_status          o_status
);

    logic                   r_recording;
    logic                   r_has_rec;
    logic [AW-1:0]          r_wp;
    logic [SAMPLE_BITS-1:0] r_q_sample [QUEUE_DEPTH];
    logic [31:0]            r_q_count  [QUEUE_DEPTH];
    logic [AW-1:0]          r_q_waddr  [QUEUE_DEPTH];
    t_class                 r_q_class  [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr;
    logic [QUEUE_AW-1:0]    r_rd_ptr;
    logic [QUEUE_AW:0]      r_cnt;

    logic          accept;
    logic          take;
    logic          rec_now;
    logic          finish;
    logic          has_next;
    logic [CW-1:0] wp_inc;
    t_class        cls;

    assign o_full    = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign accept    = i_push && !o_full;
    assign take      = i_q_take && o_q_valid;

    always_comb begin
        rec_now      = r_recording || ((i_phase == 4'd0) && !r_has_rec);
        wp_inc       = {1'b0, r_wp} + CW'(1);
        finish       = rec_now && (wp_inc >= i_eff_rl);
        has_next     = r_has_rec || finish;
        cls.do_write = rec_now;
        cls.active   = has_next && i_cfg.enable && (i_cfg.loop_length != '0)
                       && (i_cfg.sixteenth_size != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recording <= 1'b0;
            r_has_rec   <= 1'b0;
            r_wp        <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= '0;
        end else begin
            if (accept) begin
                r_recording <= rec_now && !finish;
                r_has_rec   <= has_next;
                if (rec_now) begin
                    r_wp <= finish ? '0 : wp_inc[AW-1:0];
                end
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (accept && !take) begin
                r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            end else if (take && !accept) begin
                r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_sample[r_wr_ptr] <= i_sample;
            r_q_count[r_wr_ptr]  <= i_count;
            r_q_waddr[r_wr_ptr]  <= r_wp;
            r_q_class[r_wr_ptr]  <= cls;
        end
    end

    assign o_q_sample = r_q_sample[r_rd_ptr];
    assign o_q_count  = r_q_count[r_rd_ptr];
    assign o_q_waddr  = r_q_waddr[r_rd_ptr];
    assign o_q_class  = r_q_class[r_rd_ptr];

    assign o_status.recording     = r_recording;
    assign o_status.has_recording = r_has_rec;

endmodule

// ===== hdl/bre_back.sv =====
// Back end: sample store, window arithmetic, mixing and the result register.
module bre_back
    import bre_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int STORE_DEPTH = 65536,
    parameter int AW          = 16,
    parameter int CW          = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic [CW-1:0]          i_eff_rl,
    input  logic                   i_cfg_dirty,
    input  logic                   i_q_valid,
    output logic                   o_q_take,
    input  logic [SAMPLE_BITS-1:0] i_q_sample,
    input  logic [31:0]            i_q_count,
    input  logic [AW-1:0]          i_q_waddr,
    input  t_class                 i_q_class,
    output logic                   o_out_valid,
    input  logic                   i_out_take,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic                   o_repeating
);

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_END, S_POS, S_IDX, S_MIX, S_OUT
    } t_state;

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [31:0]            r_count;
    logic [23:0]            r_start;
    logic [23:0]            r_end;
    logic [23:0]            r_pos;
    logic                   r_inside;
    logic                   r_hit;
    logic                   r_dirty;
    logic [CW-1:0]          r_fill;
    logic [SAMPLE_BITS-1:0] r_y;
    logic                   r_rep;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_rep;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    logic                   mod_start;
    logic [31:0]            mod_dividend;
    logic [23:0]            mod_divisor;
    logic [4:0]             mod_pairs;
    logic                   mod_done;
    logic [23:0]            mod_rem;

    logic                   take;
    logic                   mem_we;
    logic                   mem_re;
    logic [16:0]            idx;
    logic                   hit;
    logic                   in_window;
    logic                   out_free;
    logic [21:0]            start_prod;
    logic [21:0]            six_rc;
    logic [24:0]            end_sum;
    logic [SAMPLE_BITS-1:0] add;
    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] mixed;

    bre_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .i_pairs    (mod_pairs),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign take     = (r_state == S_IDLE) && i_q_valid;
    assign o_q_take = take;
    assign mem_we   = take && i_q_class.do_write;
    assign out_free = !r_out_valid || i_out_take;

    always_comb begin
        start_prod = (22'(i_cfg.selected_sixteenth) + 22'd1) * 22'(i_cfg.sixteenth_size);
        six_rc     = 22'(i_cfg.sixteenth_size) * 22'(i_cfg.repeat_count);
        end_sum    = 25'(mod_rem) + 25'(six_rc);
        idx        = mod_rem[16:0];
        hit        = (32'(idx) < 32'(r_fill)) && (32'(idx) < 32'(i_eff_rl));
        if (r_end < r_start) begin
            in_window = ((r_pos > r_start) && (r_pos < i_cfg.loop_length))
                        || ((r_pos != '0) && (r_pos < r_end));
        end else begin
            in_window = (r_pos > r_start) && (r_pos < r_end);
        end
        add = r_hit ? r_rd_data : '0;
        sum = {r_x[SAMPLE_BITS-1], r_x} + {add[SAMPLE_BITS-1], add};
        if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
            mixed = sum[SAMPLE_BITS] ? SAT_MIN : SAT_MAX;
        end else begin
            mixed = sum[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        mod_start    = 1'b0;
        mod_dividend = r_count;
        mod_divisor  = i_cfg.loop_length;
        mod_pairs    = MOD_PAIRS_FULL;
        mem_re       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take && i_q_class.active) begin
                    mod_start    = 1'b1;
                    mod_dividend = r_dirty ? 32'(start_prod) : i_q_count;
                end
            end
            S_START: begin
                mod_start    = mod_done;
                mod_dividend = 32'(end_sum);
            end
            S_END: begin
                mod_start = mod_done;
            end
            S_POS: begin
                mod_start    = mod_done;
                mod_dividend = {mod_rem, {IDX_ALIGN_BITS{1'b0}}};
                mod_divisor  = 24'(i_cfg.sixteenth_size);
                mod_pairs    = MOD_PAIRS_IDX;
            end
            S_IDX: begin
                mem_re = mod_done && hit;
            end
            default: begin
                mod_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_q_waddr] <= i_q_sample;
        end
        if (mem_re) begin
            r_rd_data <= mem[AW'(idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b1;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (mem_we) begin
                r_fill <= r_fill + CW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_x     <= i_q_sample;
                        r_count <= i_q_count;
                        r_y     <= i_q_sample;
                        r_rep   <= 1'b0;
                        if (!i_q_class.active) begin
                            r_state <= S_OUT;
                        end else if (r_dirty) begin
                            r_state <= S_START;
                        end else begin
                            r_state <= S_POS;
                        end
                    end
                end
                S_START: begin
                    if (mod_done) begin
                        r_start <= mod_rem;
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (mod_done) begin
                        r_end   <= mod_rem;
                        r_dirty <= 1'b0;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    if (mod_done) begin
                        r_pos   <= mod_rem;
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    if (mod_done) begin
                        r_inside <= in_window;
                        r_hit    <= hit;
                        r_state  <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (r_inside) begin
                        r_y   <= mixed;
                        r_rep <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_y;
                        r_out_rep    <= r_rep;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_dirty) begin
                r_dirty <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_repeating  = r_out_rep;

endmodule

// ===== hdl/beat_repeat_effect_unit.sv =====
// Top level of the beat repeat effect: configuration registers, front and back ends.
//
// Samples enter through a queue-style port (push/full) and results leave through
// another (empty/pop), one result beat per input beat, in order. A sample that is not
// mixed (effect disabled, nothing recorded yet, or a zero loop or sixteenth size) skips
// the remainder unit and goes unchanged to the result register. For a tested sample,
// the loop position and the position within the sixteenth are each found by a shared
// remainder unit that retires two dividend bits per cycle, followed by one registered
// read of the sample store and the saturating mix. After reset or after any
// configuration write, the first tested sample also recomputes the window start and
// end through the same unit before its own positions are found. A four-entry
// queue separates the front end, which runs the recording control at acceptance and
// writes nothing itself, from the back end, so input beats keep being taken while the
// back end works or while a finished result waits to be popped. The sample store holds
// STORE_DEPTH entries and needs no clearing pass after reset: a fill count marks how many
// entries recording has written, and any read beyond it returns zero. Configuration
// writes are always ready and must be issued only while the unit holds no sample in
// flight.
module beat_repeat_effect_unit
    import bre_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [3:0]                    i_tick_phase,
    input  logic [31:0]                   i_sample_count,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_repeating,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW + 1;

    t_cfg                   r_cfg;
    logic                   cfg_write;
    logic [31:0]            rl_sat;
    logic [CW-1:0]          eff_rl;
    logic                   q_valid;
    logic                   q_take;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic [31:0]            q_count;
    logic [AW-1:0]          q_waddr;
    t_class                 q_class;
    t_front_status          front_status;
    logic                   out_valid;
    logic [SAMPLE_BITS-1:0] sample_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_length        <= RST_LOOP_LENGTH;
            r_cfg.sixteenth_size     <= RST_SIXTEENTH_SIZE;
            r_cfg.record_length      <= RST_RECORD_LENGTH;
            r_cfg.selected_sixteenth <= RST_SELECTED_SIXTEENTH;
            r_cfg.repeat_count       <= RST_REPEAT_COUNT;
            r_cfg.enable             <= RST_ENABLE;
        end else if (cfg_write) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LOOP_LENGTH:        r_cfg.loop_length        <= i_cfg_data[23:0];
                CFG_SIXTEENTH_SIZE:     r_cfg.sixteenth_size     <= i_cfg_data[16:0];
                CFG_RECORD_LENGTH:      r_cfg.record_length      <= i_cfg_data[16:0];
                CFG_SELECTED_SIXTEENTH: r_cfg.selected_sixteenth <= i_cfg_data[3:0];
                CFG_REPEAT_COUNT:       r_cfg.repeat_count       <= i_cfg_data[4:0];
                CFG_ENABLE:             r_cfg.enable             <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // A record length of zero counts as one sample; one beyond the store is clipped.
    always_comb begin
        rl_sat = 32'(r_cfg.record_length);
        if (rl_sat == '0) begin
            rl_sat = 32'd1;
        end
        if (rl_sat > 32'(STORE_DEPTH)) begin
            rl_sat = 32'(STORE_DEPTH);
        end
        eff_rl = CW'(rl_sat);
    end

    bre_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_sample   (i_sample_in),
        .i_phase    (i_tick_phase),
        .i_count    (i_sample_count),
        .i_cfg      (r_cfg),
        .i_eff_rl   (eff_rl),
        .o_q_valid  (q_valid),
        .i_q_take   (q_take),
        .o_q_sample (q_sample),
        .o_q_count  (q_count),
        .o_q_waddr  (q_waddr),
        .o_q_class  (q_class),
        .o_status   (front_status)
    );

    bre_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_eff_rl     (eff_rl),
        .i_cfg_dirty  (cfg_write),
        .i_q_valid    (q_valid),
        .o_q_take     (q_take),
        .i_q_sample   (q_sample),
        .i_q_count    (q_count),
        .i_q_waddr    (q_waddr),
        .i_q_class    (q_class),
        .o_out_valid  (out_valid),
        .i_out_take   (pop),
        .o_sample_out (sample_out),
        .o_repeating  (o_repeating)
    );

    assign empty        = !out_valid;
    assign o_sample_out = sample_out;

    // The back end only takes a beat that the queue actually holds.
    a_take_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |-> q_valid)
        else $error("back end took a beat from an empty queue");

    // A repeated result can only exist once a recording is complete.
    a_repeat_needs_recording: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_repeating && !empty) |-> front_status.has_recording)
        else $error("repeating result without a finished recording");

    // Recording ends only by completing the recording.
    a_record_ends_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(front_status.recording) |-> front_status.has_recording)
        else $error("recording stopped without completing");

endmodule
